/* rtl/efpd_pkg.sv */
// Package for the EMG flex pattern detector: field widths, register indexes,
// the queue item type and the modulo-3 ring index helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efpd_pkg;

   localparam int CHANNELS        = 8;
   localparam int SAMPLE_W        = 8;
   localparam int WINDOW_ROWS_DEF = 512;

   localparam int LEVEL_W  = 14;
   localparam int THR_W    = 14;
   localparam int PERIOD_W = 12;
   localparam int COUNT_W  = 16;
   localparam int CHANGE_W = 8;

   localparam int REQ_DATA_W = CHANNELS * SAMPLE_W;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;

   localparam logic [THR_W-1:0]    THR_RESET    = 14'd12;
   localparam logic [PERIOD_W-1:0] IDLE_RESET   = 12'd600;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 12'd4095;
   localparam logic [CHANGE_W-1:0] CHANGE_MAX   = 8'd255;
   localparam logic [CHANGE_W-1:0] CHANGE_FLEX  = 8'd2;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
   localparam int                  LEVEL_SHIFT  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIGGER_THRESHOLD = 1'b0,
      CSR_IDLE_PERIOD       = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE   = 1'b0,
      CMD_EVALUATE = 1'b1
   } cmd_type;

   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] row_type;

   typedef struct packed {
      cmd_type cmd;
      row_type rect;
   } item_type;

   // ring index helpers: (t % 3 + 1) % 3 and (t % 3 + 2) % 3
   function automatic logic [1:0] ring_next(input logic [1:0] t);
      logic [1:0] r;
      case (t)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         2'd2:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] ring_prev(input logic [1:0] t);
      logic [1:0] r;
      case (t)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         2'd2:    r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] ring_mod(input logic [1:0] t);
      logic [1:0] r;
      case (t)
         2'd3:    r = 2'd0;
         default: r = t;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/efpd_front.sv */
// Front end of the EMG flex pattern detector: accepts request transfers,
// rectifies the channels and queues items for the back end. Uses efpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efpd_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [efpd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,
   output      logic                                item_valid,
   input  wire logic                                item_ready,
   output      efpd_pkg::item_type                  item
);

   localparam int DEPTH = 2;

   efpd_pkg::item_type slot_ff [DEPTH];
   efpd_pkg::item_type push_item;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   always_comb begin
      push_item.cmd = efpd_pkg::cmd_type'(req_tuser);
      for (int c = 0; c < efpd_pkg::CHANNELS; c++) begin
         if (req_tdata[c*efpd_pkg::SAMPLE_W + efpd_pkg::SAMPLE_W - 1]) begin
            push_item.rect[c] = ~req_tdata[c*efpd_pkg::SAMPLE_W +: efpd_pkg::SAMPLE_W]
                                + 8'd1;
         end else begin
            push_item.rect[c] = req_tdata[c*efpd_pkg::SAMPLE_W +: efpd_pkg::SAMPLE_W];
         end
      end
   end

   assign req_tready = (count_ff != 2'(DEPTH));
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/efpd_back.sv */
// Back end of the EMG flex pattern detector: window row store, column sums,
// evaluation logic, configuration registers and the result register. Uses efpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efpd_back #(
   parameter int WINDOW_ROWS = efpd_pkg::WINDOW_ROWS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [efpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [efpd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                item_valid,
   output      logic                                item_ready,
   input  wire efpd_pkg::item_type                  item,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [efpd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int ROW_W  = $clog2(WINDOW_ROWS);
   localparam int FILL_W = ROW_W + 1;
   localparam int SUM_W  = $clog2(WINDOW_ROWS * (2 ** (efpd_pkg::SAMPLE_W - 1)) + 1);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(WINDOW_ROWS - 1);
   localparam int CH = efpd_pkg::CHANNELS;

   typedef enum logic [1:0] {
      ST_ISSUE  = 2'b01,
      ST_FINISH = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   // window store
   efpd_pkg::row_type mem [WINDOW_ROWS];
   efpd_pkg::row_type rd_data_ff;
   logic              row_live_ff;

   efpd_pkg::item_type            cur_ff;
   logic [efpd_pkg::LEVEL_W-1:0]  eval_level_ff;
   logic [SUM_W-1:0]              level_sum;

   logic [SUM_W-1:0]              cs_ff [CH];
   logic [SUM_W-1:0]              cs_in [CH];
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [efpd_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [efpd_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic                          last_trig_ff, last_trig_in;
   logic [2:0]                    ring_ff, ring_in;
   logic [1:0]                    tail_ff, tail_in;
   logic                          armed_ff, armed_in;
   logic                          active_ff, active_in;
   logic [efpd_pkg::CHANGE_W-1:0] change_ff, change_in;
   logic [efpd_pkg::COUNT_W-1:0]  trig_cnt_ff, trig_cnt_in;
   logic [efpd_pkg::COUNT_W-1:0]  flex_cnt_ff, flex_cnt_in;

   logic [efpd_pkg::THR_W-1:0]    thr_ff;
   logic [efpd_pkg::PERIOD_W-1:0] idle_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [efpd_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic pop, finish, wr_en;

   assign item_ready = (state_ff == ST_ISSUE);
   assign pop        = item_valid && item_ready;
   assign finish     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign wr_en      = finish && (cur_ff.cmd == efpd_pkg::CMD_SAMPLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // level over the whole window from the current column sums
   always_comb begin
      level_sum = '0;
      for (int c = 0; c < CH; c++) begin
         level_sum = level_sum + (cs_ff[c] >> efpd_pkg::LEVEL_SHIFT);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ISSUE:  if (pop) state_in = ST_FINISH;
         ST_FINISH: if (finish) state_in = ST_ISSUE;
         default:   state_in = ST_ISSUE;
      endcase
   end

   always_comb begin
      logic                          hk;
      logic                          trig;
      logic [1:0]                    t;
      logic [1:0]                    t1;
      logic [efpd_pkg::SAMPLE_W-1:0] old_val;

      for (int c = 0; c < CH; c++) cs_in[c] = cs_ff[c];
      row_in       = row_ff;
      fill_in      = fill_ff;
      period_in    = period_ff;
      level_in     = level_ff;
      last_trig_in = last_trig_ff;
      ring_in      = ring_ff;
      tail_in      = tail_ff;
      armed_in     = armed_ff;
      active_in    = active_ff;
      change_in    = change_ff;
      trig_cnt_in  = trig_cnt_ff;
      flex_cnt_in  = flex_cnt_ff;
      hk           = 1'b0;
      trig         = 1'b0;
      t            = 2'd0;
      t1           = 2'd0;
      old_val      = '0;

      if (finish) begin
         if (cur_ff.cmd == efpd_pkg::CMD_SAMPLE) begin
            for (int c = 0; c < CH; c++) begin
               old_val  = row_live_ff ? rd_data_ff[c] : '0;
               cs_in[c] = cs_ff[c] - SUM_W'(old_val) + SUM_W'(cur_ff.rect[c]);
            end
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
            if ({1'b0, row_ff} == fill_ff) fill_in = fill_ff + 1'b1;
            if (period_ff < efpd_pkg::PERIOD_MAX) period_in = period_ff + 1'b1;
         end else begin
            // idle-period housekeeping
            hk = (period_ff >= idle_ff);
            if (hk) begin
               change_in = '0;
               period_in = '0;
               active_in = 1'b0;
               if (!active_ff) begin
                  tail_in    = 2'd1;
                  ring_in[0] = ring_ff[2];
                  ring_in[1] = 1'b0;
                  ring_in[2] = 1'b0;
               end
            end

            level_in = eval_level_ff;
            trig     = (eval_level_ff >= thr_ff);
            if (trig && !last_trig_ff && trig_cnt_ff != efpd_pkg::COUNT_MAX) begin
               trig_cnt_in = trig_cnt_ff + 1'b1;
            end
            last_trig_in = trig;

            // debounced change into the pattern ring
            t = efpd_pkg::ring_mod(tail_in);
            if (trig != ring_in[efpd_pkg::ring_prev(t)]) begin
               if (!armed_ff) begin
                  armed_in = 1'b1;
               end else begin
                  t1        = efpd_pkg::ring_next(t);
                  active_in = 1'b1;
                  if (change_in != efpd_pkg::CHANGE_MAX) change_in = change_in + 1'b1;
                  if (trig && !ring_in[efpd_pkg::ring_prev(t)] && ring_in[t1]
                      && change_in > efpd_pkg::CHANGE_FLEX) begin
                     if (flex_cnt_ff != efpd_pkg::COUNT_MAX) flex_cnt_in = flex_cnt_ff + 1'b1;
                     change_in = '0;
                  end
                  ring_in[t] = trig;
                  tail_in    = t1;
                  armed_in   = 1'b0;
               end
            end
            row_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CH; c++) cs_ff[c] <= '0;
         row_ff       <= '0;
         fill_ff      <= '0;
         period_ff    <= '0;
         level_ff     <= '0;
         last_trig_ff <= 1'b0;
         ring_ff      <= '0;
         tail_ff      <= 2'd1;
         armed_ff     <= 1'b0;
         active_ff    <= 1'b0;
         change_ff    <= '0;
         trig_cnt_ff  <= '0;
         flex_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < CH; c++) cs_ff[c] <= cs_in[c];
         row_ff       <= row_in;
         fill_ff      <= fill_in;
         period_ff    <= period_in;
         level_ff     <= level_in;
         last_trig_ff <= last_trig_in;
         ring_ff      <= ring_in;
         tail_ff      <= tail_in;
         armed_ff     <= armed_in;
         active_ff    <= active_in;
         change_ff    <= change_in;
         trig_cnt_ff  <= trig_cnt_in;
         flex_cnt_ff  <= flex_cnt_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= efpd_pkg::THR_RESET;
         idle_ff <= efpd_pkg::IDLE_RESET;
      end else if (csr_wen) begin
         case (efpd_pkg::csr_index_type'(csr_index))
            efpd_pkg::CSR_TRIGGER_THRESHOLD: thr_ff  <= csr_wdata[efpd_pkg::THR_W-1:0];
            efpd_pkg::CSR_IDLE_PERIOD:       idle_ff <= csr_wdata[efpd_pkg::PERIOD_W-1:0];
            default:                         thr_ff  <= thr_ff;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff        <= item;
         row_live_ff   <= ({1'b0, row_ff} < fill_ff);
         eval_level_ff <= efpd_pkg::LEVEL_W'(level_sum >> efpd_pkg::LEVEL_SHIFT);
      end
      if (finish) begin
         rsp_data_ff <= {1'b0, flex_cnt_in, trig_cnt_in, last_trig_in, level_in};
      end
   end

   // window store: one read port, one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[row_ff] <= cur_ff.rect;
      end
      if (pop) begin
         rd_data_ff <= mem[row_ff];
      end
   end

`ifndef SYNTHESIS
   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff != 2'd3)
      else $error("ring tail out of range");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_ROWS))
      else $error("fill count beyond window");

   a_row_in_prefix: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} <= fill_ff)
      else $error("write row past filled rows");

   a_eval_rewind: assert property (@(posedge clock) disable iff (reset)
      finish && cur_ff.cmd == efpd_pkg::CMD_EVALUATE |=> row_ff == '0)
      else $error("write row not rewound after evaluation");

   a_result_on_finish: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished item left no result");
`endif

endmodule

`default_nettype wire

/* rtl/emg_flex_pattern_detector_unit.sv */
// Top level of the EMG flex pattern detector: front end with item queue and
// back end with window store and evaluation. Uses efpd_pkg, efpd_front, efpd_back.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  ports                           content
//  request   in   req_tvalid/tready/tdata/tuser   cmd in tuser, chan0..chan7 in tdata
//  response  out  rsp_tvalid/tready/tdata         level, trigger flag, two totals
//  csr       in   csr_wen/csr_index/csr_wdata     trigger_threshold, idle_period
//
//  Back end: ST_ISSUE takes an item and reads its window row (or registers the level
//  over all column sums); ST_FINISH updates and loads the result, waiting while the
//  last result is untaken, then returns to ST_ISSUE for the next item. The row store
//  has one read and one write port. A two-entry queue lets the front take transfers
//  while the back end works or while a result waits. Synchronous active-high reset;
//  no clearing pass: a fill count marks rows never written, which read as zero.

module emg_flex_pattern_detector_unit #(
   parameter int WINDOW_ROWS = efpd_pkg::WINDOW_ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // chan0 [7:0], chan1 [15:8], ... chan7 [63:56]
   input  wire logic [efpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd [0]
   input  wire logic                              req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // activity_level [13:0], is_triggered [14], trigger_total [30:15],
   // double_flex_total [46:31], zero [47]
   output      logic [efpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [efpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [efpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic               item_valid;
   logic               item_ready;
   efpd_pkg::item_type item;

   // rectify and queue incoming transfers
   efpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // carry out samples and evaluations, hold the result until taken
   efpd_back #(
      .WINDOW_ROWS (WINDOW_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* tb/sv/emg_flex_checker.sv */
// Checker for the EMG flex pattern detector: watches the request, response and
// register ports, predicts every level report and compares it. Uses efpd_pkg.
`timescale 1ns / 1ps

module emg_flex_checker #(
   parameter int WINDOW_ROWS = efpd_pkg::WINDOW_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [efpd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [efpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [efpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [efpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              levels_due
);

   typedef struct packed {
      logic [efpd_pkg::COUNT_W-1:0] flex_total;
      logic [efpd_pkg::COUNT_W-1:0] trig_total;
      logic                         triggered;
      logic [efpd_pkg::LEVEL_W-1:0] level;
   } level_report_type;

   // detector state as seen from outside
   logic [efpd_pkg::SAMPLE_W-1:0] window_mag [WINDOW_ROWS][efpd_pkg::CHANNELS];
   logic [16:0]                   col_total [efpd_pkg::CHANNELS];
   int                            row_ptr;
   logic [efpd_pkg::PERIOD_W-1:0] period_cnt;
   logic [efpd_pkg::LEVEL_W-1:0]  level;
   logic                          triggered;
   logic                          ring [3];
   int                            tail;
   logic                          armed;
   logic                          active_seen;
   logic [efpd_pkg::CHANGE_W-1:0] changes;
   logic [efpd_pkg::COUNT_W-1:0]  trig_total;
   logic [efpd_pkg::COUNT_W-1:0]  flex_total;
   logic [efpd_pkg::THR_W-1:0]    threshold;
   logic [efpd_pkg::PERIOD_W-1:0] idle_len;

   level_report_type reports_due [$];
   level_report_type want;
   level_report_type got;
   int               shown;
   int               r;
   int               ch;

   task automatic predict_level_report(input efpd_pkg::cmd_type cmd,
                                       input logic [efpd_pkg::REQ_DATA_W-1:0] raw,
                                       output level_report_type rpt);
      int                            acc;
      int                            t;
      int                            c;
      logic [efpd_pkg::SAMPLE_W-1:0] b;
      logic [efpd_pkg::SAMPLE_W-1:0] mag;
      if (cmd == efpd_pkg::CMD_SAMPLE) begin
         for (c = 0; c < efpd_pkg::CHANNELS; c++) begin
            b = raw[c*efpd_pkg::SAMPLE_W +: efpd_pkg::SAMPLE_W];
            mag = b[efpd_pkg::SAMPLE_W-1] ? (~b + 8'd1) : b;
            col_total[c] = col_total[c] - window_mag[row_ptr][c] + mag;
            window_mag[row_ptr][c] = mag;
         end
         row_ptr = (row_ptr + 1) % WINDOW_ROWS;
         if (period_cnt != efpd_pkg::PERIOD_MAX)
            period_cnt++;
      end else begin
         // idle housekeeping first; a zero period runs it every time
         if (period_cnt >= idle_len) begin
            changes = '0;
            if (!active_seen) begin
               tail = 1;
               ring[0] = ring[2];
               ring[1] = 1'b0;
               ring[2] = 1'b0;
            end
            period_cnt = '0;
            active_seen = 1'b0;
         end
         acc = 0;
         for (c = 0; c < efpd_pkg::CHANNELS; c++)
            acc += col_total[c] / 8;
         level = acc / 8;
         if (level >= threshold) begin
            if (!triggered && trig_total != efpd_pkg::COUNT_MAX)
               trig_total++;
            triggered = 1'b1;
         end else begin
            triggered = 1'b0;
         end
         // a change must be seen twice before it enters the ring
         t = tail % 3;
         if (triggered != ring[(t + 2) % 3]) begin
            if (!armed) begin
               armed = 1'b1;
            end else begin
               active_seen = 1'b1;
               ring[t] = triggered;
               t = (t + 1) % 3;
               tail = t;
               if (changes != efpd_pkg::CHANGE_MAX)
                  changes++;
               if (ring[(t + 2) % 3] && !ring[(t + 1) % 3] && ring[t] &&
                   changes > efpd_pkg::CHANGE_FLEX) begin
                  if (flex_total != efpd_pkg::COUNT_MAX)
                     flex_total++;
                  changes = '0;
               end
               armed = 1'b0;
            end
         end
         row_ptr = 0;
      end
      rpt.level      = level;
      rpt.triggered  = triggered;
      rpt.trig_total = trig_total;
      rpt.flex_total = flex_total;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (r = 0; r < WINDOW_ROWS; r++)
            for (ch = 0; ch < efpd_pkg::CHANNELS; ch++)
               window_mag[r][ch] = '0;
         for (ch = 0; ch < efpd_pkg::CHANNELS; ch++)
            col_total[ch] = '0;
         ring[0] = 1'b0;
         ring[1] = 1'b0;
         ring[2] = 1'b0;
         row_ptr     = 0;
         period_cnt  = '0;
         level       = '0;
         triggered   = 1'b0;
         tail        = 1;
         armed       = 1'b0;
         active_seen = 1'b0;
         changes     = '0;
         trig_total  = '0;
         flex_total  = '0;
         threshold   = efpd_pkg::THR_RESET;
         idle_len    = efpd_pkg::IDLE_RESET;
         reports_due.delete();
         fail_count  = 0;
         shown       = 0;
      end else begin
         if (csr_wen) begin
            case (efpd_pkg::csr_index_type'(csr_index))
               efpd_pkg::CSR_TRIGGER_THRESHOLD:
                  threshold = csr_wdata[efpd_pkg::THR_W-1:0];
               efpd_pkg::CSR_IDLE_PERIOD:
                  idle_len  = csr_wdata[efpd_pkg::PERIOD_W-1:0];
               default: ;
            endcase
         end
         // compare a response before queuing this edge's request
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[efpd_pkg::RSP_DATA_W-2:0];
            if (reports_due.size() == 0) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("unexpected level report at %0t: %h", $realtime, rsp_tdata);
               end
            end else begin
               want = reports_due.pop_front();
               if (got.level !== want.level || got.triggered !== want.triggered ||
                   got.trig_total !== want.trig_total ||
                   got.flex_total !== want.flex_total ||
                   rsp_tdata[efpd_pkg::RSP_DATA_W-1] !== 1'b0) begin
                  fail_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("level report mismatch at %0t: expected %0d/%0d/%0d/%0d, %s",
                              $realtime, want.level, want.triggered, want.trig_total,
                              want.flex_total, "level/trig/triggers/flexes");
                     $display("   got %0d/%0d/%0d/%0d pad %b", got.level, got.triggered,
                              got.trig_total, got.flex_total,
                              rsp_tdata[efpd_pkg::RSP_DATA_W-1]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_level_report(efpd_pkg::cmd_type'(req_tuser), req_tdata, want);
            reports_due.push_back(want);
         end
      end
      levels_due <= reports_due.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the EMG flex pattern detector bench: clock, reset, stimulus, receiver
// stalls and verdict. Uses efpd_pkg, emg_flex_pattern_detector_unit, emg_flex_checker.
`timescale 1ns / 1ps

module testbench;

   // cycles allowed after the last report before a register write or the verdict
   localparam int SETTLE_CYCLES = 6;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // chan0 [7:0], chan1 [15:8], ... chan7 [63:56]
   logic [efpd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   // cmd [0]
   logic                            req_tuser  = efpd_pkg::CMD_SAMPLE;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // activity_level [13:0], is_triggered [14], trigger_total [30:15],
   // double_flex_total [46:31], zero [47]
   logic [efpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_wen    = 1'b0;
   logic [efpd_pkg::CSR_IDX_W-1:0]  csr_index  = efpd_pkg::CSR_TRIGGER_THRESHOLD;
   logic [efpd_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   int   fail_count;
   int   levels_due;
   int   sent_count = 0;
   int   burst_left = 0;
   bit   want_on    = 1'b0;
   bit   held       = 1'b0;

   emg_flex_pattern_detector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   emg_flex_checker level_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .levels_due (levels_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build one row of eight channels with magnitudes in [lo, hi] and random sign.
   // A magnitude of 128 can only be negative.
   function automatic logic [efpd_pkg::REQ_DATA_W-1:0] emg_row(input int lo, input int hi);
      logic [efpd_pkg::REQ_DATA_W-1:0] row;
      int                              m;
      int                              v;
      for (int c = 0; c < efpd_pkg::CHANNELS; c++) begin
         m = $urandom_range(hi, lo);
         v = (m == 128 || (m != 0 && $urandom_range(0, 1) == 1)) ? -m : m;
         row[c*efpd_pkg::SAMPLE_W +: efpd_pkg::SAMPLE_W] = v[efpd_pkg::SAMPLE_W-1:0];
      end
      return row;
   endfunction

   // Offer one item and hold it until the transfer. Bursts of random length are
   // separated by random gaps; a zero gap keeps tvalid high across items.
   task automatic send_item(input efpd_pkg::cmd_type cmd,
                            input logic [efpd_pkg::REQ_DATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   // Samples with magnitudes in [lo, hi], then evaluations with junk channel data.
   task automatic send_frame(input int samples, input int lo, input int hi, input int evals);
      repeat (samples) send_item(efpd_pkg::CMD_SAMPLE, emg_row(lo, hi));
      repeat (evals) send_item(efpd_pkg::CMD_EVALUATE, {$urandom, $urandom});
   endtask

   // Drain the block, wait out its pipeline, then write both registers.
   task automatic program_block(input int thr, input int idle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (levels_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= efpd_pkg::CSR_TRIGGER_THRESHOLD;
      csr_wdata <= thr[efpd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= efpd_pkg::CSR_IDLE_PERIOD;
      csr_wdata <= idle[efpd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Mostly four-row frames that swing the level across the threshold, each
   // evaluated one to three times so the debounce sees repeats; the rest short
   // random frames that break the on/off/on sequence.
   task automatic flex_episodes(input int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < 85) begin
            want_on = !want_on;
            send_frame(4, want_on ? 90 : 0, want_on ? 128 : 12, $urandom_range(1, 3));
         end else begin
            send_frame($urandom_range(0, 4), 0, 128, $urandom_range(0, 2));
         end
      end
   endtask

   // Receiver: stretches of always-ready, half-ready and mostly-stalled, plus
   // one long hold-off while the sender keeps pushing so the input backs up.
   initial begin
      int mode;
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent_count >= 200) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= ($urandom_range(0, 1) == 1);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Hard stop for a hung handshake.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: evaluate on an empty window, channel
      // extremes, evaluations back to back, debounce commit on a repeat.
      send_item(efpd_pkg::CMD_EVALUATE, '1);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h0000_0000_0000_0000);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h8080_8080_8080_8080);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h7F7F_7F7F_7F7F_7F7F);
      send_item(efpd_pkg::CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h0101_0101_0101_0101);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h807F_807F_807F_807F);
      send_item(efpd_pkg::CMD_SAMPLE, 64'h55AA_55AA_AA55_AA55);
      send_item(efpd_pkg::CMD_EVALUATE, 64'h0);
      send_item(efpd_pkg::CMD_EVALUATE, '1);
      send_item(efpd_pkg::CMD_EVALUATE, 64'h8080_8080_8080_8080);
      send_frame(4, 0, 0, 2);
      send_frame(3, 0, 0, 3);
      send_frame(1, 128, 128, 1);

      // Threshold zero always triggers; idle period zero runs housekeeping
      // on every evaluation.
      program_block(0, 0);
      repeat (8) send_frame($urandom_range(0, 4), 0, 128, $urandom_range(1, 2));

      // Flush old rows, then the flex sequences under three settings.
      program_block(30, 600);
      send_frame(16, 0, 0, 1);
      flex_episodes(28);
      program_block(30, $urandom_range(5, 40));
      flex_episodes(28);
      program_block($urandom_range(15, 40), 4095);
      flex_episodes(28);

      // Full window at the largest magnitude, wrapping the row pointer:
      // level reaches its top of 8192 and meets a threshold set to that value.
      program_block(8192, 4095);
      send_frame(514, 128, 128, 2);
      // A threshold above any level never triggers; shortest nonzero idle period.
      program_block(16383, 1);
      send_frame(2, 0, 128, 2);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (levels_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (fail_count == 0 && levels_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
